>>> rtl/fraction_reduce_gcd_unit_assert.svh
// Assertion macros for the fraction reducer.
`ifndef FRACTION_REDUCE_GCD_UNIT_ASSERT_SVH
`define FRACTION_REDUCE_GCD_UNIT_ASSERT_SVH

// Checked outside reset only.
`define FRGCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FRGCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/frgcd_pkg.sv
`default_nettype none

package frgcd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_STEPS  = 100;
    localparam int STEP_W     = $clog2(MAX_STEPS + 1);
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CAP  = 2'd2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] numerator;
        logic [DATA_WIDTH-1:0] denominator;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] divisor;
        logic [DATA_WIDTH-1:0] reduced_numerator;
        logic [DATA_WIDTH-1:0] reduced_denominator;
        logic [STATUS_W-1:0]   status;
    } rsp_t;

    typedef struct packed {
        logic                  start;
        logic [DATA_WIDTH-1:0] dividend;
        logic [DATA_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DATA_WIDTH-1:0] quotient;
        logic [DATA_WIDTH-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/fraction_reduce_gcd_unit.sv
// Operation: a zero operand is answered without any division; otherwise each remainder
// step is one pass of the shared divider, and a gcd above 1 takes two more passes to divide
// the numerator and the denominator by it.
// Throughput: one transaction at a time; req_ready is high only while the sequencer is idle,
// and a finished response may wait in its output register while the next request is taken.
// Reset: rst_n asynchronous, active low; clears the sequencer, divider control and rsp_valid.
`default_nettype none

module fraction_reduce_gcd_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire frgcd_pkg::req_t req,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output frgcd_pkg::rsp_t      rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EUC   = 3'd1;
    localparam logic [2:0] S_EUC_W = 3'd2;
    localparam logic [2:0] S_RN    = 3'd3;
    localparam logic [2:0] S_RN_W  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_RD_W  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam int W = frgcd_pkg::DATA_WIDTH;

    logic [2:0]                       state_reg, state_next;
    logic [frgcd_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [W-1:0]                     num_reg, num_next;
    logic [W-1:0]                     den_reg, den_next;
    logic [W-1:0]                     a_reg, a_next;
    logic [W-1:0]                     b_reg, b_next;
    logic [W-1:0]                     g_reg, g_next;
    logic [W-1:0]                     rn_reg, rn_next;
    logic [W-1:0]                     rd_reg, rd_next;
    logic [frgcd_pkg::STATUS_W-1:0]   st_reg, st_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    frgcd_pkg::rsp_t                  rsp_reg, rsp_next;
    frgcd_pkg::div_req_t              div_cmd;
    frgcd_pkg::div_rsp_t              div_res;
    logic                             any_zero;
    logic                             at_cap;

    assign any_zero = (num_reg == '0) || (den_reg == '0);
    assign at_cap   = step_reg == frgcd_pkg::STEP_W'(frgcd_pkg::MAX_STEPS);

    frgcd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .res   (div_res)
    );

    always_comb
    begin
        div_cmd.start    = 1'b0;
        div_cmd.dividend = a_reg;
        div_cmd.divisor  = b_reg;
        case (state_reg)
            S_EUC:
            begin
                div_cmd.start = !any_zero && !at_cap;
            end
            S_RN:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = num_reg;
                div_cmd.divisor  = g_reg;
            end
            S_RD:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = den_reg;
                div_cmd.divisor  = g_reg;
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        g_next         = g_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    num_next   = req.numerator;
                    den_next   = req.denominator;
                    a_next     = req.numerator;
                    b_next     = req.denominator;
                    step_next  = '0;
                    state_next = S_EUC;
                end
            end
            S_EUC:
            begin
                rn_next = num_reg;
                rd_next = den_reg;
                g_next  = '0;
                if (any_zero)
                begin
                    st_next    = frgcd_pkg::ST_ZERO;
                    state_next = S_FIN;
                end
                else if (at_cap)
                begin
                    st_next    = frgcd_pkg::ST_CAP;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_EUC_W;
                end
            end
            S_EUC_W:
            begin
                if (div_res.done)
                begin
                    if (div_res.remainder == '0)
                    begin
                        g_next  = b_reg;
                        st_next = frgcd_pkg::ST_OK;
                        if (b_reg > W'(1))
                        begin
                            state_next = S_RN;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else
                    begin
                        a_next     = b_reg;
                        b_next     = div_res.remainder;
                        step_next  = step_reg + 1'b1;
                        state_next = S_EUC;
                    end
                end
            end
            S_RN:
            begin
                state_next = S_RN_W;
            end
            S_RN_W:
            begin
                if (div_res.done)
                begin
                    rn_next    = div_res.quotient;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RD_W;
            end
            S_RD_W:
            begin
                if (div_res.done)
                begin
                    rd_next    = div_res.quotient;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.divisor             = g_reg;
                    rsp_next.reduced_numerator   = rn_reg;
                    rsp_next.reduced_denominator = rd_reg;
                    rsp_next.status              = st_reg;
                    rsp_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        g_reg   <= g_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        st_reg  <= st_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> rtl/frgcd_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module frgcd_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire frgcd_pkg::div_req_t cmd,
    output frgcd_pkg::div_rsp_t      res
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [frgcd_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [frgcd_pkg::DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [frgcd_pkg::DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [frgcd_pkg::DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [frgcd_pkg::DATA_WIDTH:0]   shifted;
    logic [frgcd_pkg::DATA_WIDTH:0]   diff;
    logic                            fits;

    assign shifted = {rem_reg, quo_reg[frgcd_pkg::DATA_WIDTH-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = cmd.dividend;
            dvs_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[frgcd_pkg::DATA_WIDTH-1:0]
                            : shifted[frgcd_pkg::DATA_WIDTH-1:0];
            quo_next = {quo_reg[frgcd_pkg::DATA_WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == frgcd_pkg::CNT_W'(frgcd_pkg::DATA_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/frgcd_checker.sv
`default_nettype none
`include "fraction_reduce_gcd_unit_assert.svh"

module frgcd_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire frgcd_pkg::rsp_t rsp
);

    `FRGCD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response dropped or changed while stalled")
    `FRGCD_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "request taken while a transaction is in progress")
    `FRGCD_ASSERT(a_zero_status, rsp_valid && rsp.status == frgcd_pkg::ST_ZERO |-> rsp.divisor == '0 && (rsp.reduced_numerator == '0 || rsp.reduced_denominator == '0), "zero status without a zero operand")
    `FRGCD_ASSERT(a_ok_status, rsp_valid && rsp.status == frgcd_pkg::ST_OK |-> rsp.divisor != '0, "zero divisor reported with ok status")
    `FRGCD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !rsp_valid && req_ready, "outputs not idle in reset")

endmodule

bind fraction_reduce_gcd_unit frgcd_checker u_frgcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;

    localparam int STALL_LIMIT = 8000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    frgcd_pkg::req_t fraction_req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    frgcd_pkg::rsp_t fraction_rsp;

    frgcd_pkg::rsp_t expected_fractions[$];
    frgcd_pkg::rsp_t fraction_due;
    int error_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int zero_count = 0;
    int reduced_count = 0;
    int burst_left = 10;
    int ready_run = 0;
    int idle_cycles = 0;

    fraction_reduce_gcd_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (fraction_req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (fraction_rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic frgcd_pkg::rsp_t reduce_fraction(input frgcd_pkg::req_t item);
        logic [frgcd_pkg::DATA_WIDTH-1:0] a;
        logic [frgcd_pkg::DATA_WIDTH-1:0] b;
        logic [frgcd_pkg::DATA_WIDTH-1:0] rem;
        frgcd_pkg::rsp_t res;
        bit found;
        res.divisor = '0;
        res.reduced_numerator = item.numerator;
        res.reduced_denominator = item.denominator;
        res.status = frgcd_pkg::ST_ZERO;
        if (item.numerator == '0 || item.denominator == '0)
            return res;
        a = item.numerator;
        b = item.denominator;
        found = 1'b0;
        for (int step = 0; step < frgcd_pkg::MAX_STEPS && !found; step++)
        begin
            rem = a % b;
            if (rem == '0)
                found = 1'b1;
            else
            begin
                a = b;
                b = rem;
            end
        end
        if (!found)
        begin
            res.status = frgcd_pkg::ST_CAP;
            return res;
        end
        res.status = frgcd_pkg::ST_OK;
        res.divisor = b;
        if (b > 1)
        begin
            res.reduced_numerator = item.numerator / b;
            res.reduced_denominator = item.denominator / b;
        end
        return res;
    endfunction

    function automatic logic [frgcd_pkg::DATA_WIDTH-1:0] random_operand(
        input int unsigned bits);
        logic [frgcd_pkg::DATA_WIDTH-1:0] value;
        value = $urandom;
        return value & ({frgcd_pkg::DATA_WIDTH{1'b1}} >> (frgcd_pkg::DATA_WIDTH - bits));
    endfunction

    task automatic send_fraction(input logic [frgcd_pkg::DATA_WIDTH-1:0] num,
                                 input logic [frgcd_pkg::DATA_WIDTH-1:0] den);
        frgcd_pkg::req_t item;
        int gap;
        item.numerator = num;
        item.denominator = den;
        req_valid <= 1'b1;
        fraction_req <= item;
        do @(posedge clk); while (!req_ready);
        expected_fractions.push_back(reduce_fraction(item));
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic check_field(input string name,
                               input logic [frgcd_pkg::DATA_WIDTH-1:0] want,
                               input logic [frgcd_pkg::DATA_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // receiver: ready and stall runs of random length, some long ready stretches
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            if (rsp_ready)
                ready_run <= $urandom_range(1, 25);
            else if ($urandom_range(0, 3) == 0)
                ready_run <= $urandom_range(100, 300);
            else
                ready_run <= $urandom_range(1, 30);
            rsp_ready <= !rsp_ready;
        end
        else
            ready_run <= ready_run - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_fractions.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, got %h", $time,
                         fraction_rsp);
                error_count++;
            end
            else
            begin
                fraction_due = expected_fractions.pop_front();
                check_field("divisor", fraction_due.divisor, fraction_rsp.divisor);
                check_field("reduced_numerator", fraction_due.reduced_numerator,
                            fraction_rsp.reduced_numerator);
                check_field("reduced_denominator", fraction_due.reduced_denominator,
                            fraction_rsp.reduced_denominator);
                check_field("status", frgcd_pkg::DATA_WIDTH'(fraction_due.status),
                            frgcd_pkg::DATA_WIDTH'(fraction_rsp.status));
                checked_count++;
                if (fraction_due.status == frgcd_pkg::ST_ZERO)
                    zero_count++;
                if (fraction_due.divisor > 1)
                    reduced_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t timeout: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL fraction_reduce_gcd_unit");
            $finish;
        end
    end

    task automatic test_zero_operands();
        send_fraction('0, '0);
        send_fraction('0, 32'd5);
        send_fraction(32'd7, '0);
        send_fraction('0, '1);
        send_fraction('1, '0);
    endtask

    task automatic test_extremes();
        send_fraction(32'd1, 32'd1);
        send_fraction('1, '1);
        send_fraction('1, 32'd1);
        send_fraction(32'd1, '1);
        send_fraction(32'h8000_0000, 32'hc000_0000);
        send_fraction(32'hc000_0000, 32'h8000_0000);
        send_fraction(32'd12, 32'd18);
        send_fraction(32'd17, 32'd5);
        send_fraction(32'hffff_fffe, 32'd2);
        send_fraction('1, 32'hffff_fffe);
        send_fraction(32'h5555_5555, 32'haaaa_aaaa);
    endtask

    // consecutive Fibonacci numbers take the most remainder steps
    task automatic test_worst_case_steps();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] nxt;
        lo = 64'd1;
        hi = 64'd2;
        nxt = lo + hi;
        while (nxt < 64'h1_0000_0000)
        begin
            lo = hi;
            hi = nxt;
            nxt = lo + hi;
        end
        send_fraction(hi[frgcd_pkg::DATA_WIDTH-1:0], lo[frgcd_pkg::DATA_WIDTH-1:0]);
        send_fraction(lo[frgcd_pkg::DATA_WIDTH-1:0], hi[frgcd_pkg::DATA_WIDTH-1:0]);
    endtask

    task automatic test_common_factors(input int count);
        int unsigned factor_bits;
        logic [63:0] factor;
        logic [63:0] a;
        logic [63:0] b;
        repeat (count)
        begin
            factor_bits = $urandom_range(1, 16);
            factor = 64'(random_operand(factor_bits));
            a = 64'(random_operand($urandom_range(1, frgcd_pkg::DATA_WIDTH - factor_bits)));
            b = 64'(random_operand($urandom_range(1, frgcd_pkg::DATA_WIDTH - factor_bits)));
            a = a * factor;
            b = b * factor;
            send_fraction(a[frgcd_pkg::DATA_WIDTH-1:0], b[frgcd_pkg::DATA_WIDTH-1:0]);
        end
    endtask

    task automatic test_random_operands(input int count);
        logic [frgcd_pkg::DATA_WIDTH-1:0] a;
        logic [frgcd_pkg::DATA_WIDTH-1:0] b;
        logic [63:0] multiple;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                7:
                begin
                    a = ($urandom_range(0, 1) == 0) ? '0 : random_operand($urandom_range(1, 32));
                    b = (a != '0 && $urandom_range(0, 1) == 0) ? '0 :
                        random_operand($urandom_range(1, 32));
                    if (a != '0 && b != '0)
                        a = '0;
                end
                8:
                begin
                    a = random_operand($urandom_range(1, 16));
                    multiple = 64'(a) * 64'(random_operand($urandom_range(1, 16)));
                    b = multiple[frgcd_pkg::DATA_WIDTH-1:0];
                    if ($urandom_range(0, 1) == 0)
                        {a, b} = {b, a};
                end
                9:
                begin
                    a = random_operand($urandom_range(1, 32));
                    case ($urandom_range(0, 2))
                        0: b = a;
                        1: b = '1;
                        default: b = 32'd1;
                    endcase
                end
                default:
                begin
                    a = random_operand($urandom_range(1, 32));
                    b = random_operand($urandom_range(1, 32));
                end
            endcase
            send_fraction(a, b);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_operands();
        test_extremes();
        test_worst_case_steps();
        test_common_factors(500);
        test_random_operands(880);
        req_valid <= 1'b0;
        while (expected_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_fractions.size() != 0)
        begin
            $display("%0t %0d expected results never arrived", $time,
                     expected_fractions.size());
            error_count++;
        end
        $display("Sent %0d fractions, checked %0d results, %0d errors.", sent_count,
                 checked_count, error_count);
        $display("Zero operand: %0d, divided by a common factor: %0d.", zero_count,
                 reduced_count);
        if (error_count == 0)
            $display("PASS fraction_reduce_gcd_unit");
        else
            $display("FAIL fraction_reduce_gcd_unit");
        $finish;
    end

endmodule

`default_nettype wire
